// ----- hdl/circle_least_squares_fit_macros.svh -----
// assertion macros for the circle fit block
// no dependencies; included by the modules that carry assertions
`ifndef CIRCLE_LEAST_SQUARES_FIT_MACROS_SVH
`define CIRCLE_LEAST_SQUARES_FIT_MACROS_SVH
`ifndef SYNTHESIS
`define CLSF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define CLSF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define CLSF_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define CLSF_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- hdl/clsf_pkg.sv -----
// shared types and constants of the circle fit block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package clsf_pkg;

   localparam int COORD_W        = 16;
   localparam int MAX_POINTS_DEF = 4096;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int MIN_POINTS     = 20;

   localparam logic [63:0] QMAX  = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [30:0] LIM31 = 31'h7FFF_FFFF;

   typedef enum logic [1:0] {
      FIT_OK,
      FIT_FEW_POINTS,
      FIT_SINGULAR,
      FIT_BAD_RADIUS
   } fit_status_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic                      last_point;
   } point_req_type;

   typedef struct packed {
      fit_status_type     fit_status;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic [30:0]        radius;
      logic [12:0]        points_used;
   } fit_rsp_type;

endpackage
`default_nettype wire

// ----- hdl/circle_least_squares_fit.sv -----
// circle fit top level: point accumulation, normal equations and solve sequencer
// uses clsf_pkg, clsf_mul, clsf_div, clsf_sqrt and the assertion macro header
//
// usage:
//  - a request (one point) is taken on a rising edge with start high and busy low
//  - each point is added to eight running sums through the shared 64x64
//    multiplier, which forms five products for the point in turn
//  - a request with last_point set also runs the fit; the result strobe
//    rsp_strobe is high for exactly one cycle with the fields on rsp_fit
//  - the fit time is set mostly by the bit-serial divider: eleven means and
//    up to nine row divisions, plus twenty multiplier passes and a 31-step
//    square root
//  - busy stays high from an accepted request until the sequencer is idle again
//  - the receiver cannot stall: a result is gone after its one strobe cycle
//  - the sums and the point count clear when the result goes out and at reset;
//    reset is synchronous and no result is pending after it
//  - points past MAX_POINTS in a set are dropped but a last mark still solves
`timescale 1ns / 1ps
`default_nettype none
`include "circle_least_squares_fit_macros.svh"
module circle_least_squares_fit #(
   parameter int MAX_POINTS      = clsf_pkg::MAX_POINTS_DEF,
   parameter int SOLVE_FRAC_BITS = clsf_pkg::FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  clsf_pkg::point_req_type req_point,
   output logic                    rsp_strobe,
   output clsf_pkg::fit_rsp_type   rsp_fit
);
   import clsf_pkg::*;

   localparam int F     = SOLVE_FRAC_BITS;
   localparam int CB    = COORD_W;
   localparam int NB    = $clog2(MAX_POINTS + 1);
   localparam int SXW   = CB + NB;
   localparam int XXW   = 2 * CB + NB;
   localparam int RSW   = 2 * CB + NB + 1;
   localparam int XRW   = 3 * CB + NB;
   localparam int PW    = 2 * CB;
   localparam int XPW   = 3 * CB;
   localparam int RS_SH = 2 * F - 16;

   localparam logic signed [64:0] SUB_HI = 65'(QMAX);
   localparam logic signed [64:0] SUB_LO = -SUB_HI;

   typedef enum logic [4:0] {
      S_IDLE, S_PT_MUL, S_CHECK, S_MEAN, S_MEAN_WR,
      S_PIV_RD, S_PIV_CMP, S_PIV_END, S_SCL_RD, S_SCL_GET,
      S_NRM_RD, S_NRM_DIV, S_NRM_WR, S_ELM_SEL, S_FAC_RD,
      S_FAC_GET, S_PRD_RD, S_PRD_MUL, S_SUB_RD, S_SUB_WR,
      S_ELM_NXT, S_SOL_RD, S_SOL_GET, S_RAD_A, S_RAD_B,
      S_RAD_C, S_RAD_SQ, S_FIN, S_EMIT
   } state_type;

   typedef enum logic [3:0] {
      SRC_XX, SRC_XY, SRC_X, SRC_XRR, SRC_YY, SRC_Y, SRC_YRR, SRC_RR, SRC_ONE
   } src_type;

   // matrix entries in row-major order, four columns per row
   function automatic src_type src_of(input logic [3:0] e);
      src_type s;
      unique case (e)
         4'd0:    s = SRC_XX;
         4'd1:    s = SRC_XY;
         4'd2:    s = SRC_X;
         4'd3:    s = SRC_XRR;
         4'd4:    s = SRC_XY;
         4'd5:    s = SRC_YY;
         4'd6:    s = SRC_Y;
         4'd7:    s = SRC_YRR;
         4'd8:    s = SRC_X;
         4'd9:    s = SRC_Y;
         4'd10:   s = SRC_ONE;
         default: s = SRC_RR;
      endcase
      return s;
   endfunction

   function automatic logic neg_of(input logic [3:0] e);
      return (e == 4'd3) || (e == 4'd7) || (e == 4'd11);
   endfunction

   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      return v[63] ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic [31:0] centre_of(input logic signed [63:0] coef);
      logic [63:0] m;
      logic [30:0] c31;
      m   = mag64(coef) >> (F - 7);
      c31 = (m > 64'(LIM31)) ? LIM31 : m[30:0];
      return (!coef[63] && (coef != '0)) ? (32'd0 - {1'b0, c31}) : {1'b0, c31};
   endfunction

   state_type state_ff;
   logic signed [CB-1:0]  x_ff, y_ff;
   logic                  last_ff;
   logic [CB-1:0]         ax_ff, ay_ff;
   logic [PW-1:0]         xx_ff, rr_ff;
   logic [2:0]            pk_ff;
   logic [NB-1:0]         cnt_ff;
   logic signed [SXW-1:0] sum_x_ff, sum_y_ff;
   logic signed [XXW-1:0] sum_xx_ff, sum_yy_ff, sum_xy_ff;
   logic signed [RSW-1:0] sum_rr_ff;
   logic signed [XRW-1:0] sum_x_rr_ff, sum_y_rr_ff;

   logic         op_wait_ff, op_neg_ff;
   logic         mul_go_ff, div_go_ff, sq_go_ff;
   logic [63:0]  mul_a_ff, mul_b_ff, div_num_ff, div_den_ff;
   logic [61:0]  sq_v_ff;
   logic         mul_done, div_done, sq_done;
   logic [127:0] mul_prod;
   logic [63:0]  div_quo;
   logic [30:0]  sq_root;

   logic [3:0]  ent_ff;
   logic [1:0]  col_ff, row_ff, jj_ff, lead_ff;
   logic [1:0]  perm_ff [0:2];
   logic [63:0] top_ff;
   logic signed [63:0] scale_ff, fac_ff, tmp_ff, res_ff;
   logic signed [63:0] sol_a_ff, sol_b_ff, sol_c_ff;
   logic [127:0] acc_ff, rs_ff;

   fit_status_type status_ff;
   logic [31:0] cx_ff, cy_ff;
   logic [30:0] rad_ff;
   logic        strobe_ff;
   fit_rsp_type rsp_ff;

   logic [63:0] matrix_ff [0:15];
   logic signed [63:0] rd_data_ff;
   logic        mem_we;
   logic [3:0]  mem_wa, mem_ra;
   logic signed [63:0] mem_wd;

   // combinational helpers
   logic signed [63:0] sel_sum;
   logic [63:0]        sel_mag;
   logic               mean_neg;
   logic [63:0]        qm_mag;
   logic signed [64:0] diff;
   logic signed [63:0] diff_sat;
   logic [127:0]       sq, ct, rs;
   logic               c_pos, bad_rad;

   always_comb begin
      unique case (src_of(ent_ff))
         SRC_XX:  sel_sum = 64'(sum_xx_ff);
         SRC_XY:  sel_sum = 64'(sum_xy_ff);
         SRC_X:   sel_sum = 64'(sum_x_ff);
         SRC_XRR: sel_sum = 64'(sum_x_rr_ff);
         SRC_YY:  sel_sum = 64'(sum_yy_ff);
         SRC_Y:   sel_sum = 64'(sum_y_ff);
         SRC_YRR: sel_sum = 64'(sum_y_rr_ff);
         SRC_RR:  sel_sum = 64'(sum_rr_ff);
         default: sel_sum = '0;
      endcase
      sel_mag  = mag64(sel_sum);
      mean_neg = sel_sum[63] ^ neg_of(ent_ff);

      qm_mag = (|mul_prod[127:63+F]) ? QMAX : 64'(mul_prod[62+F:F]);

      diff = 65'(rd_data_ff) - 65'(tmp_ff);
      if (diff > SUB_HI) begin
         diff_sat = 64'(SUB_HI);
      end else if (diff < SUB_LO) begin
         diff_sat = 64'(SUB_LO);
      end else begin
         diff_sat = 64'(diff);
      end

      sq    = acc_ff >> 2;
      ct    = 128'(mag64(sol_c_ff)) << F;
      c_pos = !sol_c_ff[63] && (sol_c_ff != '0);
      if (c_pos) begin
         rs      = sq - ct;
         bad_rad = sq <= ct;
      end else begin
         rs      = sq + ct;
         bad_rad = rs == '0;
      end
   end

   // matrix port control follows the sequencer state
   always_comb begin
      mem_we = 1'b0;
      mem_wa = '0;
      mem_wd = res_ff;
      mem_ra = '0;
      unique case (state_ff)
         S_PIV_RD:  mem_ra = {perm_ff[row_ff], col_ff};
         S_SCL_RD:  mem_ra = {perm_ff[col_ff], col_ff};
         S_NRM_RD:  mem_ra = {perm_ff[col_ff], jj_ff};
         S_FAC_RD:  mem_ra = {perm_ff[row_ff], col_ff};
         S_PRD_RD:  mem_ra = {perm_ff[col_ff], jj_ff};
         S_SUB_RD:  mem_ra = {perm_ff[row_ff], jj_ff};
         S_SOL_RD:  mem_ra = {perm_ff[row_ff], 2'd3};
         S_MEAN_WR: begin
            mem_we = 1'b1;
            mem_wa = ent_ff;
         end
         S_NRM_WR: begin
            mem_we = 1'b1;
            mem_wa = {perm_ff[col_ff], jj_ff};
         end
         S_SUB_WR: begin
            mem_we = 1'b1;
            mem_wa = {perm_ff[row_ff], jj_ff};
            mem_wd = diff_sat;
         end
         default: mem_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         matrix_ff[mem_wa] <= mem_wd;
      end
      rd_data_ff <= matrix_ff[mem_ra];
   end

   clsf_mul u_mul (
      .clock (clock),
      .reset (reset),
      .go    (mul_go_ff),
      .op_a  (mul_a_ff),
      .op_b  (mul_b_ff),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   clsf_div #(
      .FRAC (F)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .go    (div_go_ff),
      .num   (div_num_ff),
      .den   (div_den_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   clsf_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .go    (sq_go_ff),
      .value (sq_v_ff),
      .done  (sq_done),
      .root  (sq_root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         op_wait_ff  <= 1'b0;
         mul_go_ff   <= 1'b0;
         div_go_ff   <= 1'b0;
         sq_go_ff    <= 1'b0;
         strobe_ff   <= 1'b0;
         cnt_ff      <= '0;
         sum_x_ff    <= '0;
         sum_y_ff    <= '0;
         sum_xx_ff   <= '0;
         sum_yy_ff   <= '0;
         sum_xy_ff   <= '0;
         sum_rr_ff   <= '0;
         sum_x_rr_ff <= '0;
         sum_y_rr_ff <= '0;
      end else begin
         mul_go_ff <= 1'b0;
         div_go_ff <= 1'b0;
         sq_go_ff  <= 1'b0;
         strobe_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  x_ff    <= req_point.point_x;
                  y_ff    <= req_point.point_y;
                  last_ff <= req_point.last_point;
                  ax_ff   <= req_point.point_x[CB-1] ? CB'(-req_point.point_x)
                                                     : CB'(req_point.point_x);
                  ay_ff   <= req_point.point_y[CB-1] ? CB'(-req_point.point_y)
                                                     : CB'(req_point.point_y);
                  pk_ff   <= '0;
                  state_ff <= (cnt_ff < NB'(MAX_POINTS)) ? S_PT_MUL : S_CHECK;
               end
            end
            S_PT_MUL: begin
               if (!op_wait_ff) begin
                  op_wait_ff <= 1'b1;
                  mul_go_ff  <= 1'b1;
                  unique case (pk_ff)
                     3'd0: begin mul_a_ff <= 64'(ax_ff); mul_b_ff <= 64'(ax_ff); end
                     3'd1: begin mul_a_ff <= 64'(ay_ff); mul_b_ff <= 64'(ay_ff); end
                     3'd2: begin mul_a_ff <= 64'(ax_ff); mul_b_ff <= 64'(ay_ff); end
                     3'd3: begin mul_a_ff <= 64'(ax_ff); mul_b_ff <= 64'(rr_ff); end
                     default: begin mul_a_ff <= 64'(ay_ff); mul_b_ff <= 64'(rr_ff); end
                  endcase
               end else if (mul_done) begin
                  op_wait_ff <= 1'b0;
                  pk_ff      <= pk_ff + 3'd1;
                  unique case (pk_ff)
                     3'd0: begin
                        xx_ff     <= mul_prod[PW-1:0];
                        sum_xx_ff <= sum_xx_ff + XXW'(mul_prod[PW-1:0]);
                     end
                     3'd1: begin
                        rr_ff     <= xx_ff + mul_prod[PW-1:0];
                        sum_yy_ff <= sum_yy_ff + XXW'(mul_prod[PW-1:0]);
                        sum_rr_ff <= sum_rr_ff + RSW'(xx_ff) + RSW'(mul_prod[PW-1:0]);
                     end
                     3'd2: begin
                        sum_xy_ff <= (x_ff[CB-1] ^ y_ff[CB-1])
                                     ? sum_xy_ff - XXW'(mul_prod[PW-1:0])
                                     : sum_xy_ff + XXW'(mul_prod[PW-1:0]);
                     end
                     3'd3: begin
                        sum_x_rr_ff <= x_ff[CB-1] ? sum_x_rr_ff - XRW'(mul_prod[XPW-1:0])
                                                  : sum_x_rr_ff + XRW'(mul_prod[XPW-1:0]);
                     end
                     default: begin
                        sum_y_rr_ff <= y_ff[CB-1] ? sum_y_rr_ff - XRW'(mul_prod[XPW-1:0])
                                                  : sum_y_rr_ff + XRW'(mul_prod[XPW-1:0]);
                        sum_x_ff <= sum_x_ff + SXW'(x_ff);
                        sum_y_ff <= sum_y_ff + SXW'(y_ff);
                        cnt_ff   <= cnt_ff + 1'b1;
                        state_ff <= S_CHECK;
                     end
                  endcase
               end
            end
            S_CHECK: begin
               status_ff <= FIT_OK;
               cx_ff     <= '0;
               cy_ff     <= '0;
               rad_ff    <= '0;
               ent_ff    <= '0;
               if (!last_ff) begin
                  state_ff <= S_IDLE;
               end else if (cnt_ff < NB'(MIN_POINTS)) begin
                  status_ff <= FIT_FEW_POINTS;
                  state_ff  <= S_EMIT;
               end else begin
                  state_ff <= S_MEAN;
               end
            end
            S_MEAN: begin
               if (src_of(ent_ff) == SRC_ONE) begin
                  res_ff   <= 64'(1) << F;
                  state_ff <= S_MEAN_WR;
               end else if (!op_wait_ff) begin
                  op_wait_ff <= 1'b1;
                  div_go_ff  <= 1'b1;
                  div_num_ff <= sel_mag;
                  div_den_ff <= 64'(cnt_ff);
               end else if (div_done) begin
                  op_wait_ff <= 1'b0;
                  res_ff     <= mean_neg ? -signed'(div_quo) : signed'(div_quo);
                  state_ff   <= S_MEAN_WR;
               end
            end
            S_MEAN_WR: begin
               if (ent_ff == 4'd11) begin
                  perm_ff[0] <= 2'd0;
                  perm_ff[1] <= 2'd1;
                  perm_ff[2] <= 2'd2;
                  col_ff     <= '0;
                  row_ff     <= '0;
                  lead_ff    <= '0;
                  top_ff     <= '0;
                  state_ff   <= S_PIV_RD;
               end else begin
                  ent_ff   <= ent_ff + 4'd1;
                  state_ff <= S_MEAN;
               end
            end
            S_PIV_RD: state_ff <= S_PIV_CMP;
            S_PIV_CMP: begin
               // strict compare keeps the earliest row on ties
               if (mag64(rd_data_ff) > top_ff) begin
                  top_ff  <= mag64(rd_data_ff);
                  lead_ff <= row_ff;
               end
               if (row_ff == 2'd2) begin
                  state_ff <= S_PIV_END;
               end else begin
                  row_ff   <= row_ff + 2'd1;
                  state_ff <= S_PIV_RD;
               end
            end
            S_PIV_END: begin
               if (top_ff == '0) begin
                  status_ff <= FIT_SINGULAR;
                  state_ff  <= S_EMIT;
               end else begin
                  perm_ff[lead_ff] <= perm_ff[col_ff];
                  perm_ff[col_ff]  <= perm_ff[lead_ff];
                  state_ff         <= S_SCL_RD;
               end
            end
            S_SCL_RD: state_ff <= S_SCL_GET;
            S_SCL_GET: begin
               scale_ff <= rd_data_ff;
               jj_ff    <= col_ff;
               state_ff <= S_NRM_RD;
            end
            S_NRM_RD: state_ff <= S_NRM_DIV;
            S_NRM_DIV: begin
               if (!op_wait_ff) begin
                  op_wait_ff <= 1'b1;
                  div_go_ff  <= 1'b1;
                  div_num_ff <= mag64(rd_data_ff);
                  div_den_ff <= mag64(scale_ff);
                  op_neg_ff  <= rd_data_ff[63] ^ scale_ff[63];
               end else if (div_done) begin
                  op_wait_ff <= 1'b0;
                  res_ff     <= op_neg_ff ? -signed'(div_quo) : signed'(div_quo);
                  state_ff   <= S_NRM_WR;
               end
            end
            S_NRM_WR: begin
               if (jj_ff == 2'd3) begin
                  row_ff   <= '0;
                  state_ff <= S_ELM_SEL;
               end else begin
                  jj_ff    <= jj_ff + 2'd1;
                  state_ff <= S_NRM_RD;
               end
            end
            S_ELM_SEL: state_ff <= (row_ff == col_ff) ? S_ELM_NXT : S_FAC_RD;
            S_FAC_RD:  state_ff <= S_FAC_GET;
            S_FAC_GET: begin
               fac_ff   <= rd_data_ff;
               jj_ff    <= col_ff;
               state_ff <= S_PRD_RD;
            end
            S_PRD_RD: state_ff <= S_PRD_MUL;
            S_PRD_MUL: begin
               if (!op_wait_ff) begin
                  op_wait_ff <= 1'b1;
                  mul_go_ff  <= 1'b1;
                  mul_a_ff   <= mag64(fac_ff);
                  mul_b_ff   <= mag64(rd_data_ff);
                  op_neg_ff  <= fac_ff[63] ^ rd_data_ff[63];
               end else if (mul_done) begin
                  op_wait_ff <= 1'b0;
                  tmp_ff     <= op_neg_ff ? -signed'(qm_mag) : signed'(qm_mag);
                  state_ff   <= S_SUB_RD;
               end
            end
            S_SUB_RD: state_ff <= S_SUB_WR;
            S_SUB_WR: begin
               if (jj_ff == 2'd3) begin
                  state_ff <= S_ELM_NXT;
               end else begin
                  jj_ff    <= jj_ff + 2'd1;
                  state_ff <= S_PRD_RD;
               end
            end
            S_ELM_NXT: begin
               if (row_ff != 2'd2) begin
                  row_ff   <= row_ff + 2'd1;
                  state_ff <= S_ELM_SEL;
               end else if (col_ff == 2'd2) begin
                  row_ff   <= '0;
                  state_ff <= S_SOL_RD;
               end else begin
                  col_ff   <= col_ff + 2'd1;
                  row_ff   <= col_ff + 2'd1;
                  lead_ff  <= col_ff + 2'd1;
                  top_ff   <= '0;
                  state_ff <= S_PIV_RD;
               end
            end
            S_SOL_RD: state_ff <= S_SOL_GET;
            S_SOL_GET: begin
               unique case (row_ff)
                  2'd0:    sol_a_ff <= rd_data_ff;
                  2'd1:    sol_b_ff <= rd_data_ff;
                  default: sol_c_ff <= rd_data_ff;
               endcase
               if (row_ff == 2'd2) begin
                  state_ff <= S_RAD_A;
               end else begin
                  row_ff   <= row_ff + 2'd1;
                  state_ff <= S_SOL_RD;
               end
            end
            S_RAD_A: begin
               if (!op_wait_ff) begin
                  op_wait_ff <= 1'b1;
                  mul_go_ff  <= 1'b1;
                  mul_a_ff   <= mag64(sol_a_ff);
                  mul_b_ff   <= mag64(sol_a_ff);
               end else if (mul_done) begin
                  op_wait_ff <= 1'b0;
                  acc_ff     <= mul_prod;
                  state_ff   <= S_RAD_B;
               end
            end
            S_RAD_B: begin
               if (!op_wait_ff) begin
                  op_wait_ff <= 1'b1;
                  mul_go_ff  <= 1'b1;
                  mul_a_ff   <= mag64(sol_b_ff);
                  mul_b_ff   <= mag64(sol_b_ff);
               end else if (mul_done) begin
                  op_wait_ff <= 1'b0;
                  acc_ff     <= acc_ff + mul_prod;
                  state_ff   <= S_RAD_C;
               end
            end
            S_RAD_C: begin
               if (bad_rad) begin
                  status_ff <= FIT_BAD_RADIUS;
                  state_ff  <= S_EMIT;
               end else begin
                  rs_ff    <= rs >> RS_SH;
                  state_ff <= S_RAD_SQ;
               end
            end
            S_RAD_SQ: begin
               if (|rs_ff[127:62]) begin
                  rad_ff   <= LIM31;
                  state_ff <= S_FIN;
               end else if (!op_wait_ff) begin
                  op_wait_ff <= 1'b1;
                  sq_go_ff   <= 1'b1;
                  sq_v_ff    <= rs_ff[61:0];
               end else if (sq_done) begin
                  op_wait_ff <= 1'b0;
                  rad_ff     <= sq_root;
                  state_ff   <= S_FIN;
               end
            end
            S_FIN: begin
               cx_ff    <= centre_of(sol_a_ff);
               cy_ff    <= centre_of(sol_b_ff);
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               strobe_ff          <= 1'b1;
               rsp_ff.fit_status  <= status_ff;
               rsp_ff.center_x    <= cx_ff;
               rsp_ff.center_y    <= cy_ff;
               rsp_ff.radius      <= rad_ff;
               rsp_ff.points_used <= 13'(cnt_ff);
               cnt_ff      <= '0;
               sum_x_ff    <= '0;
               sum_y_ff    <= '0;
               sum_xx_ff   <= '0;
               sum_yy_ff   <= '0;
               sum_xy_ff   <= '0;
               sum_rr_ff   <= '0;
               sum_x_rr_ff <= '0;
               sum_y_rr_ff <= '0;
               state_ff    <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy       = state_ff != S_IDLE;
   assign rsp_strobe = strobe_ff;
   assign rsp_fit    = rsp_ff;

   `CLSF_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe, "result strobe held past one cycle")
   `CLSF_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accepted request did not raise busy")
   `CLSF_ASSERT_NOW(a_fail_zero, clock, reset, rsp_strobe && (rsp_fit.fit_status != FIT_OK), (rsp_fit.center_x == 0) && (rsp_fit.center_y == 0) && (rsp_fit.radius == 0), "failed fit with nonzero fields")
   `CLSF_ASSERT_NOW(a_sums_cleared, clock, reset, rsp_strobe, (cnt_ff == '0) && (sum_x_ff == '0), "sums not cleared with result")

endmodule
`default_nettype wire

// ----- hdl/clsf_mul.sv -----
// shared 64x64 unsigned multiplier, four 32x32 partial products accumulated in turn
// depends on nothing but its ports
`timescale 1ns / 1ps
`default_nettype none
module clsf_mul (
   input  logic         clock,
   input  logic         reset,
   input  logic         go,
   input  logic [63:0]  op_a,
   input  logic [63:0]  op_b,
   output logic         done,
   output logic [127:0] prod
);

   logic [63:0]  a_ff, b_ff;
   logic [2:0]   step_ff;
   logic         run_ff, done_ff;
   logic [63:0]  pp_ff;
   logic [1:0]   ppk_ff;
   logic [127:0] acc_ff;
   logic [31:0]  half_a, half_b;
   logic [6:0]   shift;

   always_comb begin
      half_a = step_ff[1] ? a_ff[63:32] : a_ff[31:0];
      half_b = step_ff[0] ? b_ff[63:32] : b_ff[31:0];
      shift  = {(2'(ppk_ff[1]) + 2'(ppk_ff[0])), 5'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            a_ff    <= op_a;
            b_ff    <= op_b;
            acc_ff  <= '0;
            step_ff <= '0;
            run_ff  <= 1'b1;
         end else if (run_ff) begin
            if (step_ff != 3'd4) begin
               pp_ff  <= half_a * half_b;
               ppk_ff <= step_ff[1:0];
            end
            // partial product of the previous step lands here
            if (step_ff != 3'd0) begin
               acc_ff <= acc_ff + (128'(pp_ff) << shift);
            end
            if (step_ff == 3'd4) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               step_ff <= step_ff + 3'd1;
            end
         end
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule
`default_nettype wire

// ----- hdl/clsf_div.sv -----
// shared restoring divider: (num << FRAC) / den, one quotient bit per cycle
// uses clsf_pkg for the saturation limit
`timescale 1ns / 1ps
`default_nettype none
module clsf_div #(
   parameter int FRAC = clsf_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [63:0] num,
   input  logic [63:0] den,
   output logic        done,
   output logic [63:0] quo
);
   import clsf_pkg::*;

   localparam int DW = 64 + FRAC;
   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] num_ff, quo_ff;
   logic [63:0]   den_ff, rem_ff;
   logic [CW-1:0] cnt_ff;
   logic          run_ff, done_ff;
   logic [64:0]   trial;
   logic          fits;

   always_comb begin
      trial = {rem_ff, num_ff[DW-1]};
      fits  = trial >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            num_ff <= DW'(num) << FRAC;
            den_ff <= den;
            rem_ff <= '0;
            quo_ff <= '0;
            cnt_ff <= CW'(DW);
            run_ff <= 1'b1;
         end else if (run_ff) begin
            num_ff <= num_ff << 1;
            if (fits) begin
               rem_ff <= 64'(trial - {1'b0, den_ff});
               quo_ff <= {quo_ff[DW-2:0], 1'b1};
            end else begin
               rem_ff <= trial[63:0];
               quo_ff <= {quo_ff[DW-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_comb begin
      if (den_ff == '0) begin
         quo = '0;
      end else if (|quo_ff[DW-1:63]) begin
         quo = QMAX;
      end else begin
         quo = {1'b0, quo_ff[62:0]};
      end
   end

   assign done = done_ff;

endmodule
`default_nettype wire

// ----- hdl/clsf_sqrt.sv -----
// integer square root of a 62-bit value, one result bit per cycle
// depends on nothing but its ports
`timescale 1ns / 1ps
`default_nettype none
module clsf_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [61:0] value,
   output logic        done,
   output logic [30:0] root
);

   logic [61:0] v_ff, res_ff, bit_ff;
   logic        run_ff, done_ff;
   logic [62:0] trial;
   logic        fits;

   always_comb begin
      trial = 63'(res_ff) + 63'(bit_ff);
      fits  = 63'(v_ff) >= trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            v_ff   <= value;
            res_ff <= '0;
            bit_ff <= 62'(1) << 60;
            run_ff <= 1'b1;
         end else if (run_ff) begin
            if (fits) begin
               v_ff   <= 62'(63'(v_ff) - trial);
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            if (bit_ff[0]) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = res_ff[30:0];

endmodule
`default_nettype wire
